>>> rtl/core/pts_pkg.sv
// Shared types and constants of the priority time-slot scheduler.
// Depends on nothing; every other file but pts_ram imports it.
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = 5;
    localparam int TIME_BITS = 32;

    localparam logic [TIME_BITS-1:0] TIME_NEVER = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [3:0]           task_index;
        logic [TIME_BITS-1:0] current_time;
        logic [TIME_BITS-1:0] interval;
        logic [TIME_BITS-1:0] duration;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic [3:0]           chosen_index;
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] run_count;
        logic                 late;
        logic [TIME_BITS-1:0] lateness;
    } t_out_word;

    // Status handed from the scan engine to the channel logic.
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_core_stat;

endpackage

>>> rtl/core/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pts_core.sv
// Task table and scan sequencer: four table RAMs, one shared compare unit.
// Depends on pts_pkg and pts_ram.
module pts_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  pts_pkg::t_in_word          i_item,
    input  logic [pts_pkg::CNT_W-1:0]  i_task_count,
    input  logic                       i_res_take,
    output pts_pkg::t_out_word         o_res,
    output pts_pkg::t_core_stat        o_stat
);
    import pts_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_EVAL = 6'b000100,
        S_CMP  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [TIX_W-1:0]     r_k, n_k;
    logic [TIX_W-1:0]     r_j, n_j;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_sched, n_sched;
    logic [TIME_BITS:0]   r_end, n_end;
    t_out_word            r_res, n_res;

    logic [TIX_W-1:0]     j_next;
    logic [CNT_W-1:0]     count;
    logic                 load_ok;
    logic [TIX_W-1:0]     wr_addr;
    logic [TIX_W-1:0]     nr_raddr;
    logic                 nr_we, pd_we, ml_we, rn_we;
    logic [TIME_BITS-1:0] nr_wdata, rn_wdata;
    logic [TIME_BITS-1:0] nr_q, pd_q, ml_q, rn_q;
    logic [TIME_BITS-1:0] cand_start;
    logic                 late;

    pts_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_next_run (
        .i_clk(i_clk), .i_we(nr_we), .i_waddr(wr_addr), .i_wdata(nr_wdata),
        .i_raddr(nr_raddr), .o_rdata(nr_q)
    );
    pts_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_period (
        .i_clk(i_clk), .i_we(pd_we), .i_waddr(wr_addr), .i_wdata(i_item.interval),
        .i_raddr(r_k), .o_rdata(pd_q)
    );
    pts_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_max_length (
        .i_clk(i_clk), .i_we(ml_we), .i_waddr(wr_addr), .i_wdata(i_item.duration),
        .i_raddr(r_k), .o_rdata(ml_q)
    );
    pts_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_runs (
        .i_clk(i_clk), .i_we(rn_we), .i_waddr(wr_addr), .i_wdata(rn_wdata),
        .i_raddr(r_k), .o_rdata(rn_q)
    );

    assign j_next     = r_j + 1'b1;
    assign count      = (int'(i_task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : i_task_count;
    assign load_ok    = int'(i_item.task_index) < MAX_TASKS;
    assign wr_addr    = (r_state == S_IDLE) ? TIX_W'(i_item.task_index) : r_k;
    assign cand_start = (r_now > nr_q) ? r_now : nr_q;
    assign late       = r_now > r_sched;

    // The next_run port reads the candidate in S_LOAD and the
    // higher-priority entries one after another during the compare pass.
    always_comb begin
        case (r_state)
            S_EVAL:  nr_raddr = '0;
            S_CMP:   nr_raddr = j_next;
            default: nr_raddr = r_k;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_j      = r_j;
        n_now    = r_now;
        n_start  = r_start;
        n_sched  = r_sched;
        n_end    = r_end;
        n_res    = r_res;
        nr_we    = 1'b0;
        pd_we    = 1'b0;
        ml_we    = 1'b0;
        rn_we    = 1'b0;
        nr_wdata = i_item.current_time;
        rn_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.operation == OP_LOAD) begin
                        nr_we = load_ok;
                        pd_we = load_ok;
                        ml_we = load_ok;
                        rn_we = load_ok;
                    end else begin
                        n_now = i_item.current_time;
                        if (count == '0) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            n_k     = TIX_W'(count - 1'b1);
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_sched = nr_q;
                n_start = cand_start;
                n_end   = {1'b0, cand_start} + {1'b0, ml_q};
                n_j     = '0;
                if (nr_q == TIME_NEVER) begin
                    if (r_k == '0) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_LOAD;
                    end
                end else if (r_k == '0) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Candidate must finish no later than entry r_j is due.
                if (r_end > {1'b0, nr_q}) begin
                    if (r_k == '0) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_LOAD;
                    end
                end else if (j_next == r_k) begin
                    n_state = S_UPD;
                end else begin
                    n_j = j_next;
                end
            end
            S_UPD: begin
                nr_we    = 1'b1;
                nr_wdata = (pd_q == TIME_NEVER) ? TIME_NEVER : r_start + pd_q;
                rn_we    = 1'b1;
                rn_wdata = rn_q + 1'b1;
                n_res.found        = 1'b1;
                n_res.chosen_index = 4'(r_k);
                n_res.start_time   = r_start;
                n_res.run_count    = rn_q + 1'b1;
                n_res.late         = late;
                n_res.lateness     = late ? r_now - r_sched : '0;
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k     <= n_k;
        r_j     <= n_j;
        r_now   <= n_now;
        r_start <= n_start;
        r_sched <= n_sched;
        r_end   <= n_end;
        r_res   <= n_res;
    end

    assign o_res            = r_res;
    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.res_valid = (r_state == S_OUT);

    a_cmp_below_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j < r_k))
        else $error("compare index reached the candidate");

    a_query_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_item.operation == OP_QUERY)
        |=> (r_state != S_IDLE))
        else $error("query did not start a scan");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_item.operation == OP_LOAD)
        |=> (r_state == S_IDLE))
        else $error("load left the idle state");

    a_late_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_res.late == (r_res.lateness != '0)))
        else $error("late flag disagrees with lateness");

endmodule

>>> rtl/core/priority_time_slot_scheduler.sv
// Top level of the priority time-slot scheduler: channels, task count
// register and output register. Depends on pts_pkg and pts_core.
//
// Usage. Input words arrive on i_in_valid / o_in_stall / i_in_data and
// results leave on o_out_valid / i_out_stall / o_out_data; a word moves at
// a rising edge where valid is high and stall is low. A load word writes
// one task entry in the cycle it is accepted and gives no result. A query
// word always gives exactly one result word.
// Scan. A query scans the entries in use from the lowest priority up.
// For each candidate the table is read (S_LOAD), its start and end time
// are formed (S_EVAL), and its end time is compared against each
// higher-priority entry in turn on the one shared compare unit (S_CMP);
// the table's single next_run read port gives one entry at a time. The
// chosen entry is then updated (S_UPD). The input is stalled during the
// whole scan and while its result waits; a load does not stall the input.
// Reset (synchronous, active low) clears the task count to zero and empties
// the output register; table contents are undefined until loaded.
// When the receiver stalls, the result word holds in the output register;
// the next word is still accepted, and a new result waits inside the scan
// engine until the output register frees up. The user must write the task
// count (i_cfg_we / i_cfg_data) only while idle; the block does not check.
module priority_time_slot_scheduler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pts_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pts_pkg::t_in_word          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pts_pkg::t_out_word         o_out_data
);
    import pts_pkg::*;

    logic [CNT_W-1:0] r_task_count;
    logic             r_out_valid;
    t_out_word        r_out_data;
    t_out_word        core_res;
    t_core_stat       core_stat;
    logic             in_accept;
    logic             res_take;

    assign o_in_stall = core_stat.busy;
    assign in_accept  = i_in_valid && !core_stat.busy;
    // The output register can take a new word when empty or draining now.
    assign res_take   = !r_out_valid || !i_out_stall;

    pts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_accept),
        .i_item       (i_in_data),
        .i_task_count (r_task_count),
        .i_res_take   (res_take),
        .o_res        (core_res),
        .o_stat       (core_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (core_stat.res_valid && res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (core_stat.res_valid && res_take) begin
            r_out_data <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the priority time-slot scheduler.
// Depends on pts_pkg and priority_time_slot_scheduler from the RTL tree.
module testbench;
    import pts_pkg::*;

    // Cycles to let the block settle once nothing is expected any more.
    localparam int SETTLE_CYCLES = 200;
    // Cycles without progress after which the run is declared hung.
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 155;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_LONG
    } t_stall_mode;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_data;

    priority_time_slot_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Words waiting to be sent, and results the scheduler owes us.
    t_in_word  pending_words[$];
    t_out_word due_results[$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;

    // Our own copy of the task table and the task count register.
    logic [CNT_W-1:0]     task_cnt = '0;
    logic [TIME_BITS-1:0] due_at   [MAX_TASKS];
    logic [TIME_BITS-1:0] every    [MAX_TASKS];
    logic [TIME_BITS-1:0] run_len  [MAX_TASKS];
    logic [TIME_BITS-1:0] run_tally[MAX_TASKS];

    // Applies one accepted word to the table copy. A load rewrites one entry;
    // a query picks a task the way the scheduler must and queues the result.
    function automatic void schedule_word(input t_in_word w);
        t_out_word            r;
        logic [TIME_BITS-1:0] sched;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS:0]   finish;
        int                   span;
        bit                   picked;
        bit                   fits;
        r      = '0;
        picked = 1'b0;
        if (w.operation == OP_LOAD) begin
            if (int'(w.task_index) < MAX_TASKS) begin
                due_at[w.task_index]    = w.current_time;
                every[w.task_index]     = w.interval;
                run_len[w.task_index]   = w.duration;
                run_tally[w.task_index] = '0;
            end
            return;
        end
        // A count above the table size behaves as the table size.
        span = (int'(task_cnt) > MAX_TASKS) ? MAX_TASKS : int'(task_cnt);
        for (int k = span - 1; k >= 0; k--) begin
            if (!picked && due_at[k] != TIME_NEVER) begin
                sched  = due_at[k];
                start  = (w.current_time > sched) ? w.current_time : sched;
                // The end time is compared at full width, so it never wraps.
                finish = {1'b0, start} + {1'b0, run_len[k]};
                fits   = 1'b1;
                for (int j = 0; j < k; j++) begin
                    if (finish > {1'b0, due_at[j]}) begin
                        fits = 1'b0;
                    end
                end
                if (fits) begin
                    picked = 1'b1;
                    // A run-once task parks at the all-ones time for good.
                    if (every[k] != TIME_NEVER) begin
                        due_at[k] = start + every[k];
                    end else begin
                        due_at[k] = TIME_NEVER;
                    end
                    run_tally[k]   = run_tally[k] + 1'b1;
                    r.found        = 1'b1;
                    r.chosen_index = k[3:0];
                    r.start_time   = start;
                    r.run_count    = run_tally[k];
                    r.late         = (w.current_time > sched);
                    r.lateness     = r.late ? (w.current_time - sched) : '0;
                end
            end
        end
        due_results.push_back(r);
    endfunction

    function automatic void check_field(input string name,
                                        input logic [TIME_BITS-1:0] want_v,
                                        input logic [TIME_BITS-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Sender. It hands out queued words in bursts of random length, with
    // random gaps between them, and never changes a word while it is stalled.
    int       burst_left = 1;
    int       gap_left   = 0;
    logic     next_valid;
    t_in_word next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                schedule_word(i_in_data);
            end
            next_valid = 1'b0;
            next_word  = i_in_data;
            if (i_in_valid && o_in_stall) begin
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() != 0) begin
                next_valid = 1'b1;
                next_word  = pending_words.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    // About a quarter of the bursts run straight on.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_word;
        end
    end

    // Receiver. Results are checked against the oldest expectation, and the
    // stall follows its own pattern: none, sparse random cycles, or long
    // stretches, switching mode at random times.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        hold_high  = 1'b0;
    logic        next_stall;
    t_out_word   want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("found", TIME_BITS'(want.found),
                                TIME_BITS'(o_out_data.found));
                    check_field("chosen_index", TIME_BITS'(want.chosen_index),
                                TIME_BITS'(o_out_data.chosen_index));
                    check_field("start_time", want.start_time, o_out_data.start_time);
                    check_field("run_count", want.run_count, o_out_data.run_count);
                    check_field("late", TIME_BITS'(want.late),
                                TIME_BITS'(o_out_data.late));
                    check_field("lateness", want.lateness, o_out_data.lateness);
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left  = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE: begin
                    next_stall = 1'b0;
                end
                STALL_SPARSE: begin
                    next_stall = ($urandom_range(0, 2) == 0);
                end
                default: begin
                    if (run_left == 0) begin
                        hold_high = !hold_high;
                        run_left  = hold_high ? $urandom_range(1, 30) : $urandom_range(1, 10);
                    end else begin
                        run_left--;
                    end
                    next_stall = hold_high;
                end
            endcase
            i_out_stall <= next_stall;
        end
    end

    // Any accepted word or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
        end
        $display("priority_time_slot_scheduler regression: fail");
        $finish;
    end

    function automatic void push_load(input int idx, input logic [TIME_BITS-1:0] t,
                                      input logic [TIME_BITS-1:0] ivl,
                                      input logic [TIME_BITS-1:0] dur);
        t_in_word w;
        w.operation    = OP_LOAD;
        w.task_index   = idx[3:0];
        w.current_time = t;
        w.interval     = ivl;
        w.duration     = dur;
        pending_words.push_back(w);
    endfunction

    // Fields that a query does not use carry random bits.
    function automatic void push_query(input logic [TIME_BITS-1:0] t);
        t_in_word w;
        w.operation    = OP_QUERY;
        w.task_index   = $urandom_range(0, 15);
        w.current_time = t;
        w.interval     = $urandom;
        w.duration     = $urandom;
        pending_words.push_back(w);
    endfunction

    // Waits until every word is sent and every result is back, then lets the
    // block finish any scan still running before the register is touched.
    task automatic drain_block();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_task_count(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        task_cnt    = v;
        @(negedge i_clk);
    endtask

    // One random phase. Most entries are reloaded around a moving time base
    // so that tasks keep competing; then loads and queries mix, with the
    // query time creeping forward and now and then jumping anywhere.
    task automatic fill_random_phase(input int n);
        logic [TIME_BITS-1:0] clk_now;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] ivl;
        logic [TIME_BITS-1:0] dur;
        int                   pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            clk_now = $urandom_range(0, 5000);
        end else if (pick < 8) begin
            clk_now = $urandom;
        end else begin
            // Close to the top, so that times wrap during the phase.
            clk_now = TIME_NEVER - $urandom_range(0, 2000);
        end
        for (int e = 0; e < MAX_TASKS; e++) begin
            if ($urandom_range(0, 3) != 0) begin
                push_load(e, clk_now + $urandom_range(0, 300), $urandom_range(1, 400),
                          $urandom_range(0, 60));
            end
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 25) begin
                pick = $urandom_range(0, 19);
                t    = (pick < 2) ? TIME_NEVER :
                       (pick < 3) ? $urandom : clk_now + $urandom_range(0, 400);
                pick = $urandom_range(0, 9);
                ivl  = (pick < 7) ? $urandom_range(1, 400) :
                       (pick == 7) ? TIME_NEVER : (pick == 8) ? '0 : $urandom;
                pick = $urandom_range(0, 9);
                dur  = (pick < 7) ? $urandom_range(0, 60) :
                       (pick == 7) ? TIME_NEVER : (pick == 8) ? '0 : $urandom;
                push_load($urandom_range(0, 15), t, ivl, dur);
            end else begin
                push_query(($urandom_range(0, 19) == 0) ? $urandom : clk_now);
                clk_now = clk_now + $urandom_range(0, 80);
            end
        end
    endtask

    logic [CNT_W-1:0] phase_counts[7] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd3};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. With no entries in use a query finds nothing. The
        // loads below all land beyond the count and are only scanned later.
        write_task_count(5'd0);
        push_query(32'd5);
        // Entry 0 sits at the all-ones time and is never picked.
        push_load(0, TIME_NEVER, 32'd5, 32'd5);
        // Entry 1 runs once, with no length, at time zero.
        push_load(1, '0, TIME_NEVER, '0);
        // Entry 2 would end past the top of the time range; the end time
        // must not wrap, so it stays blocked.
        push_load(2, 32'hFFFF_FFF0, 32'h20, TIME_NEVER);
        for (int e = 3; e < MAX_TASKS; e++) begin
            push_load(e, 32'(100 * e), 32'(50 + e), 32'(e));
        end
        drain_block();

        write_task_count(5'd16);
        push_query('0);
        push_query('0);
        push_query(32'd1000);
        push_query(TIME_NEVER);
        push_query(32'd1500);
        push_query('0);
        drain_block();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_task_count((p < 7) ? phase_counts[p] : CNT_W'($urandom_range(0, 31)));
            fill_random_phase(PHASE_WORDS);
            drain_block();
        end

        if (mismatch_count == 0) begin
            $display("priority_time_slot_scheduler regression: pass");
        end else begin
            $display("priority_time_slot_scheduler regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pts_pkg.sv
rtl/core/pts_ram.sv
rtl/core/pts_core.sv
rtl/core/priority_time_slot_scheduler.sv
tb/testbench.sv
